// ===== hw/rtl/mfm_pkg.sv =====
// ----------------------------------------------------------------------------
// mfm_pkg
// Shared types and constants for the motor feedback monitor.
// ----------------------------------------------------------------------------
package mfm_pkg;

   localparam int unsigned ResWidth    = 17;
   localparam int unsigned CfgWidth    = 16;
   localparam int unsigned AngleWidth  = 16;
   localparam int unsigned ValueWidth  = 16;
   localparam int unsigned PosWidth    = 32;
   localparam int unsigned CountWidth  = 16;
   localparam int unsigned IndexWidth  = 3;
   localparam int unsigned ReqDataWidth = 48;
   localparam int unsigned RspDataWidth = 56;

   localparam logic [ResWidth-1:0]   ResolutionReset = 17'd8192;
   localparam logic [CfgWidth-1:0]   OfflineReset    = 16'd50;
   localparam logic [CfgWidth-1:0]   StopSpeedReset  = 16'd50;
   localparam logic [CountWidth-1:0] CountMax        = '1;

   typedef enum logic [1:0] {
      KIND_FRAME = 2'd0,
      KIND_TICK  = 2'd1,
      KIND_CHECK = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      ST_OFFLINE = 2'd0,
      ST_STOP    = 2'd1,
      ST_RUNNING = 2'd2,
      ST_STALL   = 2'd3
   } status_type;

   typedef enum logic [IndexWidth-1:0] {
      REG_RESOLUTION   = 3'd0,
      REG_POS_ENABLE   = 3'd1,
      REG_STALL_ENABLE = 3'd2,
      REG_STALL_SOURCE = 3'd3,
      REG_STALL_THRESH = 3'd4,
      REG_STALL_TIME   = 3'd5,
      REG_OFFLINE_LIM  = 3'd6,
      REG_STOP_SPEED   = 3'd7
   } reg_index_type;

   // Magnitude of a 16-bit signed value, one bit wider.
   function automatic logic [ValueWidth:0] magnitude(input logic [ValueWidth-1:0] v);
      logic [ValueWidth:0] ext;
      ext = {v[ValueWidth-1], v};
      return v[ValueWidth-1] ? (~ext + 1'b1) : ext;
   endfunction

endpackage

// ===== hw/rtl/motor_feedback_monitor.sv =====
// ----------------------------------------------------------------------------
// motor_feedback_monitor
// Multi-turn encoder unwrap, feedback age tracking and stall detection.
// ----------------------------------------------------------------------------
// Each request is one of three kinds: a feedback frame, a millisecond tick or
// a status check, and each produces exactly one response carrying the motor
// status, the multi-turn position and the stall counter after that request.
// A request is processed on acceptance: the state and response registers are
// both loaded at the edge that accepts it, so a new request can be taken every
// cycle while the response register is empty or being drained. Configuration
// must be written through the csr port only while idle; this is not enforced.
module motor_feedback_monitor (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // angle [15:0], speed [31:16], current [47:32]
   input  logic [mfm_pkg::ReqDataWidth-1:0] req_tdata,
   // kind [1:0]
   input  logic [1:0]                      req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // status [1:0], position [33:2], stall_checks [49:34], zero [55:50]
   output logic [mfm_pkg::RspDataWidth-1:0] rsp_tdata,
   input  logic                            csr_we,
   input  logic [mfm_pkg::IndexWidth-1:0]  csr_index,
   input  logic [mfm_pkg::ResWidth-1:0]    csr_wdata
);
   import mfm_pkg::*;

   logic [ResWidth-1:0]   resolution_ff;
   logic                  pos_enable_ff;
   logic                  stall_enable_ff;
   logic                  stall_source_ff;
   logic [CfgWidth-1:0]   stall_thresh_ff;
   logic [CfgWidth-1:0]   stall_time_ff;
   logic [CfgWidth-1:0]   offline_lim_ff;
   logic [CfgWidth-1:0]   stop_speed_ff;

   logic signed [PosWidth-1:0] pos_ff, pos_in;
   logic [AngleWidth-1:0]      prev_angle_ff, prev_angle_in;
   logic                       seen_ff, seen_in;
   logic [CountWidth-1:0]      age_ff, age_in;
   logic [CountWidth-1:0]      count_ff, count_in;
   status_type                 state_ff, state_in;
   logic [ValueWidth-1:0]      speed_ff, speed_in;
   logic [ValueWidth-1:0]      current_ff, current_in;

   logic                       rsp_valid_ff, rsp_valid_in;
   logic [RspDataWidth-1:0]    rsp_data_ff, rsp_data_in;

   logic                       req_accept;
   kind_type                   kind;
   logic [AngleWidth-1:0]      angle;
   logic signed [AngleWidth:0] diff;
   logic [AngleWidth:0]        adiff;
   logic signed [AngleWidth+2:0] delta;
   logic signed [PosWidth+1:0] sum;
   logic [ValueWidth:0]        speed_mag;
   logic [ValueWidth:0]        watched_mag;
   logic [CountWidth-1:0]      count_inc;
   logic [CountWidth+3:0]      count_x10;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_accept = req_tvalid && req_tready;
   assign kind       = kind_type'(req_tuser);
   assign angle      = req_tdata[15:0];

   // Angle unwrap and saturating position sum.
   assign diff  = $signed({1'b0, angle}) - $signed({1'b0, prev_angle_ff});
   assign adiff = diff[AngleWidth] ? 17'(-diff) : 17'(diff);
   always_comb begin
      delta = {{2{diff[AngleWidth]}}, diff};
      if (adiff > {1'b0, resolution_ff[ResWidth-1:1]}) begin
         if (diff[AngleWidth]) begin
            delta = delta + $signed({2'b00, resolution_ff});
         end else begin
            delta = delta - $signed({2'b00, resolution_ff});
         end
      end
      sum = {{2{pos_ff[PosWidth-1]}}, pos_ff} + {{(PosWidth-AngleWidth-1){delta[AngleWidth+2]}}, delta};
   end

   assign speed_mag   = magnitude(speed_ff);
   assign watched_mag = magnitude(stall_source_ff ? current_ff : speed_ff);
   assign count_inc   = (count_ff == CountMax) ? count_ff : count_ff + 1'b1;
   assign count_x10   = {1'b0, count_inc, 3'b000} + {3'b000, count_inc, 1'b0};

   always_comb begin
      pos_in        = pos_ff;
      prev_angle_in = prev_angle_ff;
      seen_in       = seen_ff;
      age_in        = age_ff;
      count_in      = count_ff;
      state_in      = state_ff;
      speed_in      = speed_ff;
      current_in    = current_ff;
      if (req_accept) begin
         unique case (kind)
            KIND_FRAME: begin
               speed_in   = req_tdata[31:16];
               current_in = req_tdata[47:32];
               age_in     = '0;
               if (!pos_enable_ff) begin
                  pos_in  = '0;
                  seen_in = 1'b0;
               end else if (!seen_ff) begin
                  prev_angle_in = angle;
                  seen_in       = 1'b1;
               end else begin
                  prev_angle_in = angle;
                  if (sum > 34'sh0_7FFF_FFFF) begin
                     pos_in = 32'sh7FFF_FFFF;
                  end else if (sum < -34'sh0_8000_0000) begin
                     pos_in = 32'sh8000_0000;
                  end else begin
                     pos_in = sum[PosWidth-1:0];
                  end
               end
            end
            KIND_TICK: begin
               if (age_ff != CountMax) begin
                  age_in = age_ff + 1'b1;
               end
            end
            KIND_CHECK: begin
               if (age_ff > offline_lim_ff) begin
                  state_in = ST_OFFLINE;
               end else begin
                  state_in = (speed_mag < {1'b0, stop_speed_ff}) ? ST_STOP : ST_RUNNING;
                  if (stall_enable_ff) begin
                     if (watched_mag > {1'b0, stall_thresh_ff} && state_in == ST_STOP) begin
                        count_in = count_inc;
                        // count > time / 10 is the same test as 10 * count > time.
                        if (count_x10 > {4'b0000, stall_time_ff}) begin
                           state_in = ST_STALL;
                        end
                     end else begin
                        count_in = '0;
                     end
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      if (req_accept) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {6'b000000, count_in, pos_in, state_in};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         resolution_ff   <= ResolutionReset;
         pos_enable_ff   <= 1'b0;
         stall_enable_ff <= 1'b0;
         stall_source_ff <= 1'b0;
         stall_thresh_ff <= '0;
         stall_time_ff   <= '0;
         offline_lim_ff  <= OfflineReset;
         stop_speed_ff   <= StopSpeedReset;
      end else if (csr_we) begin
         unique case (reg_index_type'(csr_index))
            REG_RESOLUTION:   resolution_ff   <= csr_wdata;
            REG_POS_ENABLE:   pos_enable_ff   <= csr_wdata[0];
            REG_STALL_ENABLE: stall_enable_ff <= csr_wdata[0];
            REG_STALL_SOURCE: stall_source_ff <= csr_wdata[0];
            REG_STALL_THRESH: stall_thresh_ff <= csr_wdata[CfgWidth-1:0];
            REG_STALL_TIME:   stall_time_ff   <= csr_wdata[CfgWidth-1:0];
            REG_OFFLINE_LIM:  offline_lim_ff  <= csr_wdata[CfgWidth-1:0];
            REG_STOP_SPEED:   stop_speed_ff   <= csr_wdata[CfgWidth-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff        <= '0;
         prev_angle_ff <= '0;
         seen_ff       <= 1'b0;
         age_ff        <= CountMax;
         count_ff      <= '0;
         state_ff      <= ST_OFFLINE;
         speed_ff      <= '0;
         current_ff    <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         pos_ff        <= pos_in;
         prev_angle_ff <= prev_angle_in;
         seen_ff       <= seen_in;
         age_ff        <= age_in;
         count_ff      <= count_in;
         state_ff      <= state_in;
         speed_ff      <= speed_in;
         current_ff    <= current_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

`ifndef SYNTH
   a_stall_has_count: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_STALL |-> count_ff != '0)
      else $error("stall status with a zero stall counter");

   a_pos_disabled_clears: assert property (@(posedge clock) disable iff (reset)
      req_accept && kind == KIND_FRAME && !pos_enable_ff |=> pos_ff == '0)
      else $error("frame with position disabled left a nonzero position");

   a_accept_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> rsp_tvalid)
      else $error("accepted request produced no response");
`endif

endmodule
